### hdl/swmf_pkg.sv
package swmf_pkg;

  // Sample and result field widths.
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COUNT_W  = 6;

  // Default window limit. The window holds up to one fewer samples than this.
  localparam int unsigned WINDOW_LIMIT_DEF = 10;

  // What one cell shows its neighbors: a held value, and whether it is held
  // and not greater than the incoming sample.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                le;
  } cell_link_t;

endpackage

### hdl/swmf_cell.sv
module swmf_cell
  import swmf_pkg::*;
#(
  parameter int unsigned WINDOW_LIMIT = WINDOW_LIMIT_DEF,
  parameter int unsigned IDX          = 0,
  localparam int unsigned HOLD        = WINDOW_LIMIT - 1,
  localparam int unsigned AW          = $clog2(HOLD),
  localparam int unsigned CW          = $clog2(WINDOW_LIMIT)
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [CW-1:0]              fill_i,
  // Own contents before the update, and those of the right-hand neighbor.
  output cell_link_t                 raw_o,
  output logic [AW-1:0]              age_o,
  input  cell_link_t                 right_i,
  input  logic [AW-1:0]              right_age_i,
  // Set when the evicted entry sits left of here (shl_i), at or left (shl_o).
  input  logic                       shl_i,
  output logic                       shl_o,
  // Contents after the eviction, from the left-hand neighbor and from here.
  input  cell_link_t                 left_i,
  input  logic [AW-1:0]              left_age_i,
  output cell_link_t                 rem_o,
  output logic [AW-1:0]              rem_age_o
);

  localparam logic [CW-1:0] IDX_C   = CW'(IDX);
  localparam logic [AW-1:0] AGE_OUT = AW'(HOLD - 1);

  logic [SAMPLE_W-1:0] value_q, value_d;
  logic [AW-1:0]       age_q, age_d;
  logic                vld;
  logic                evict;

  assign vld   = IDX_C < fill_i;
  assign evict = vld && (age_q == AGE_OUT);

  always_comb begin
    raw_o.value = value_q;
    raw_o.le    = vld && ($signed(value_q) <= sample_i);
  end
  assign age_o = age_q;

  assign shl_o = shl_i | evict;

  // Close the gap left by the evicted entry.
  always_comb begin
    if (shl_o) begin
      rem_o     = right_i;
      rem_age_o = right_age_i;
    end else begin
      rem_o     = raw_o;
      rem_age_o = age_q;
    end
  end

  // Insert the new sample after every held sample of equal or lower value.
  always_comb begin
    priority if (rem_o.le) begin
      value_d = rem_o.value;
      age_d   = rem_age_o + AW'(1);
    end else if (left_i.le) begin
      value_d = sample_i;
      age_d   = '0;
    end else begin
      value_d = left_i.value;
      age_d   = left_age_i + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

endmodule

### hdl/swmf_median.sv
module swmf_median
  import swmf_pkg::*;
#(
  parameter int unsigned WINDOW_LIMIT = WINDOW_LIMIT_DEF,
  localparam int unsigned HOLD        = WINDOW_LIMIT - 1,
  localparam int unsigned CW          = $clog2(WINDOW_LIMIT)
) (
  input  logic [SAMPLE_W-1:0]        values_i [HOLD],
  input  logic [CW-1:0]              fill_i,
  output logic signed [SAMPLE_W-1:0] median_o
);

  logic [CW-1:0]       lo_idx, hi_idx;
  logic [SAMPLE_W-1:0] lo_val, hi_val;
  logic [SAMPLE_W:0]   sum;

  // For an odd count both indexes name the middle entry.
  assign hi_idx = fill_i >> 1;
  assign lo_idx = (fill_i - CW'(1)) >> 1;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < HOLD; i++) begin
      if (lo_idx == CW'(i)) lo_val = lo_val | values_i[i];
      if (hi_idx == CW'(i)) hi_val = hi_val | values_i[i];
    end
  end

  // Sign-extended sum; dropping the low bit rounds toward minus infinity.
  assign sum      = {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};
  assign median_o = $signed(sum[SAMPLE_W:1]);

endmodule

### hdl/sliding_window_median_filter_unit.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | sample_i (24 b, signed)
// out     | output    | out_valid_o / out_stall_i | median_o (24 b, signed),
//         |           |                         | held_count_o (6 b)
//
// One beat is accepted per cycle when the result side keeps up. The edge that
// takes an input beat loads the cell row; a later edge, once the output
// register is free, moves the median into the output register, where the
// result beat waits to be taken.
// Reset clears the fill count and the handshake state; the cell contents are
// not reset, since only the first fill-count cells are ever looked at.
// A stall on the result side holds the output register; the input side then
// stalls as soon as the cell row holds a window whose median is waiting, so at
// most one beat sits between the output register and the input.
module sliding_window_median_filter_unit
  import swmf_pkg::*;
#(
  parameter int unsigned WINDOW_LIMIT = WINDOW_LIMIT_DEF,
  localparam int unsigned HOLD        = WINDOW_LIMIT - 1,
  localparam int unsigned AW          = $clog2(HOLD),
  localparam int unsigned CW          = $clog2(WINDOW_LIMIT)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] median_o,
  output logic [COUNT_W-1:0]         held_count_o
);

  // Handshake state. The pending flag says the cell row holds a window whose
  // median has not yet been moved into the output register.
  logic                       pend_q, pend_d;
  logic                       out_vld_q, out_vld_d;
  logic signed [SAMPLE_W-1:0] median_q;
  logic [COUNT_W-1:0]         count_q;
  logic [CW-1:0]              fill_q, fill_d;

  logic                       accept;
  logic                       out_free;
  logic                       capture;
  logic signed [SAMPLE_W-1:0] median_now;

  // The output register is free when empty or when its beat is taken now.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign capture    = pend_q && out_free;
  // A new beat may update the cells in the same cycle that the previous
  // window's median is captured, so back-to-back beats flow without a gap.
  assign in_stall_o = pend_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Once full, every beat evicts the oldest sample, so the count stays put.
  always_comb begin
    fill_d = fill_q;
    if (accept && (fill_q != CW'(HOLD))) begin
      fill_d = fill_q + CW'(1);
    end
  end

  always_comb begin
    priority if (accept) begin
      pend_d = 1'b1;
    end else if (capture) begin
      pend_d = 1'b0;
    end else begin
      pend_d = pend_q;
    end
  end

  always_comb begin
    priority if (capture) begin
      out_vld_d = 1'b1;
    end else if (out_free) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
      fill_q    <= '0;
    end else begin
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      median_q <= median_now;
      count_q  <= COUNT_W'(fill_q);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign median_o     = median_q;
  assign held_count_o = count_q;

  // Cell row. Each cell holds one entry of the sorted window with its age.
  // The eviction flag ripples left to right; each cell then picks its new
  // entry from itself or its neighbors.
  cell_link_t          raw   [HOLD];
  logic [AW-1:0]       age   [HOLD];
  cell_link_t          rem   [HOLD];
  logic [AW-1:0]       rem_age [HOLD];
  logic                shl   [HOLD+1];
  logic [SAMPLE_W-1:0] values [HOLD];

  assign shl[0] = 1'b0;

  for (genvar i = 0; i < HOLD; i++) begin : g_cell
    cell_link_t    left_link;
    logic [AW-1:0] left_age;
    cell_link_t    right_link;
    logic [AW-1:0] right_age;

    // Left of the first cell stands a virtual entry below every sample, so
    // the new sample lands in the first cell when every held sample is greater.
    if (i == 0) begin : g_first
      assign left_link = '{value: '0, le: 1'b1};
      assign left_age  = '0;
    end else begin : g_inner
      assign left_link = rem[i-1];
      assign left_age  = rem_age[i-1];
    end

    // Right of the last cell stands an empty entry.
    if (i == HOLD - 1) begin : g_last
      assign right_link = '{value: '0, le: 1'b0};
      assign right_age  = '0;
    end else begin : g_mid
      assign right_link = raw[i+1];
      assign right_age  = age[i+1];
    end

    swmf_cell #(
      .WINDOW_LIMIT(WINDOW_LIMIT),
      .IDX         (i)
    ) u_cell (
      .clk_i      (clk_i),
      .load_i     (accept),
      .sample_i   (sample_i),
      .fill_i     (fill_q),
      .raw_o      (raw[i]),
      .age_o      (age[i]),
      .right_i    (right_link),
      .right_age_i(right_age),
      .shl_i      (shl[i]),
      .shl_o      (shl[i+1]),
      .left_i     (left_link),
      .left_age_i (left_age),
      .rem_o      (rem[i]),
      .rem_age_o  (rem_age[i])
    );

    assign values[i] = raw[i].value;
  end

  // Median of the window now held, read from the middle cells.
  swmf_median #(
    .WINDOW_LIMIT(WINDOW_LIMIT)
  ) u_median (
    .values_i(values),
    .fill_i  (fill_q),
    .median_o(median_now)
  );

endmodule

### tb/testbench.sv
module testbench;
  import swmf_pkg::*;

  localparam int unsigned HOLD_DEPTH = WINDOW_LIMIT_DEF - 1;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam int unsigned RANDOM_ITEMS = 1125;

  // One expected result: the window median and the number of samples held.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic [COUNT_W-1:0]         held_count;
  } filter_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] median_o;
  logic [COUNT_W-1:0]         held_count_o;

  // Samples still inside the window, oldest first.
  logic signed [SAMPLE_W-1:0] recent_samples[$];
  filter_result_t             expected_medians[$];
  logic signed [SAMPLE_W-1:0] last_sample;
  int                         error_count;
  int                         random_sent;
  bit                         quiet_mode;

  sliding_window_median_filter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .median_o     (median_o),
    .held_count_o (held_count_o)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    out_stall_i = 1'b0;
    error_count = 0;
    random_sent = 0;
    quiet_mode  = 1'b0;
    last_sample = '0;
  end

  always #5 clk_i = ~clk_i;

  // Adds a sample to the window, drops the oldest one past the hold depth,
  // and works out the median of what is left.
  function automatic filter_result_t predict_window_median(
    input logic signed [SAMPLE_W-1:0] sample
  );
    logic signed [SAMPLE_W-1:0] ordered[HOLD_DEPTH];
    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W-1:0] v;
    filter_result_t             res;
    int                         n;
    int                         j;
    recent_samples = {recent_samples, sample};
    if (recent_samples.size() > HOLD_DEPTH) begin
      void'(recent_samples.pop_front());
    end
    n = recent_samples.size();
    for (int i = 0; i < n; i++) begin
      v = recent_samples[i];
      j = i;
      while (j > 0 && ordered[j-1] > v) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = v;
    end
    if (n % 2 == 1) begin
      res.median = ordered[n/2];
    end else begin
      // The sum is one bit wider, so the shift rounds toward minus infinity
      // without overflow.
      pair_sum   = ordered[n/2-1] + ordered[n/2];
      res.median = pair_sum[SAMPLE_W:1];
    end
    res.held_count = n[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, got_v);
    error_count++;
  endtask

  // Idle lengths: mostly none, sometimes a few cycles, rarely a long stretch.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Both sides of the block are watched in one process, so an input beat
  // and a result beat on the same edge are handled in a fixed order.
  always @(posedge clk_i) begin
    filter_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_medians = {expected_medians, predict_window_median(sample_i)};
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_medians.size() == 0) begin
          report_mismatch("unexpected result beat, median", 0, median_o);
        end else begin
          want = expected_medians.pop_front();
          if (median_o !== want.median) begin
            report_mismatch("median", want.median, median_o);
          end
          if (held_count_o !== want.held_count) begin
            report_mismatch("held_count", want.held_count, held_count_o);
          end
        end
      end
    end
  end

  // Result side stall: open most cycles, with stalls of random length.
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (quiet_mode || $urandom_range(0, 99) < 70) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        hold = idle_cycles();
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Sends one sample beat. Valid stays high on return so that back-to-back
  // beats never lower and raise it in the same step.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= sample;
    do @(posedge clk_i); while (in_stall_o);
    last_sample = sample;
  endtask

  // Waits at clock edges, so the beat taken at the current edge is already
  // among the expected results when the count is looked at.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_medians.size() != 0);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_W'($urandom());
      4, 5:       return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
      6: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      7:       return SAMPLE_W'(SAMPLE_MAX - $urandom_range(0, 15));
      8:       return SAMPLE_W'(SAMPLE_MIN + $urandom_range(0, 15));
      default: return last_sample;
    endcase
  endfunction

  // Extremes while the window grows, rounding of an odd pair sum toward
  // minus infinity, equal values, and the first evictions once it is full.
  task automatic test_directed_extremes();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('1);
    send_sample(24'sd1);
    send_sample(24'sd256);
    send_sample(-24'sd256);
    for (int i = 0; i < 5; i++) begin
      send_sample(24'sd42);
    end
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample('1);
    send_sample('0);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);
  endtask

  // A stretch with no idling on either side, so beats go at full rate.
  task automatic test_full_rate();
    quiet_mode = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_sample(random_sample());
      random_sent++;
    end
    quiet_mode = 1'b0;
  endtask

  // The sender stops until every result is out, then picks up again.
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) begin
      send_sample(random_sample());
      random_sent++;
    end
    hold_until_drained();
    for (int i = 0; i < 20; i++) begin
      send_sample(random_sample());
      random_sent++;
    end
  endtask

  // Random bursts: loose samples, rising and falling ramps that insert at
  // the ends of the order, and runs of equal values.
  task automatic test_random_bursts();
    int burst;
    int kind;
    logic signed [SAMPLE_W-1:0] base;
    logic signed [SAMPLE_W-1:0] step;
    while (random_sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 20);
      kind  = $urandom_range(0, 3);
      base  = random_sample();
      step  = SAMPLE_W'($signed($urandom_range(0, 512)) - 256);
      for (int i = 0; i < burst; i++) begin
        case (kind)
          0, 1:    send_sample(random_sample());
          2:       send_sample(SAMPLE_W'(base + step * i));
          default: send_sample(base);
        endcase
        random_sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_full_rate();
    test_drain_pause();
    test_random_bursts();
    hold_until_drained();
    // Give stray result beats time to show.
    repeat (8) @(posedge clk_i);
    if (expected_medians.size() != 0) begin
      report_mismatch("results never delivered", 0, expected_medians.size());
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
